// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the page store.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked at every rising clock edge outside reset.
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Consequent checked at the clock after the antecedent holds.
`define SPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/spr_pkg.sv -----
// Shared constants, codes and types of the slotted page record store.
package spr_pkg;
    localparam int DATA_BYTES = 1024;
    localparam int MAX_SLOTS  = 64;
    localparam int SLOT_BYTES = 4;

    localparam int ADDR_W  = $clog2(DATA_BYTES);
    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int SCNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int LEN_W   = 11;
    localparam int PAGE_W  = 31;
    localparam int REQ_W   = 4;
    localparam int BIDX_W  = 10;
    localparam int BYTE_W  = 8;
    localparam int STS_W   = 2;
    localparam int SRAM_W  = 2 * LEN_W;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INIT      = 4'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BEGIN = 4'd1;
    localparam logic [REQ_W-1:0] REQ_INS_BYTE  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_FIRST     = 4'd4;
    localparam logic [REQ_W-1:0] REQ_NEXT      = 4'd5;
    localparam logic [REQ_W-1:0] REQ_LENGTH    = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ      = 4'd7;

    // result status codes
    localparam logic [STS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STS_W-1:0] ST_DONE = 2'd1;
    localparam logic [STS_W-1:0] ST_FAIL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_FINDE, S_FINDU, S_SLOT_WAIT, S_BYTE_WAIT,
        S_DEL_RD, S_MV_CHK, S_MV_WR, S_FIX_RD, S_FIX_WR, S_TRIM, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_INS_CLR, OP_INS_BYTE, OP_DEL_START,
        OP_DEL_FAIL, OP_FAIL, OP_SCAN_FROM0, OP_SCAN_NEXT, OP_SLOT_RD,
        OP_IDX_INC, OP_INS_COMMIT, OP_SCAN_HIT, OP_SCAN_DONE, OP_LEN_OUT,
        OP_BYTE_RD, OP_BYTE_OUT, OP_DEL_LOAD, OP_MV_RD, OP_MV_WR, OP_DEL_CLR,
        OP_FIX_RD, OP_FIX_WR, OP_DEL_SPACE, OP_TRIM, OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             rid_ok;
        logic             idx_end;
        logic             idx_used;
        logic             rd_ok;
        logic             mv_more;
        logic             trim_more;
    } t_dp_stat;
endpackage

// ----- rtl/spr_intf.sv -----
// Request and response channel interfaces of the page store.
interface spr_req_if;
    import spr_pkg::*;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [PAGE_W-1:0]   rid_page;
    logic [SLOT_W-1:0]   rid_slot;
    logic [LEN_W-1:0]    new_length;
    logic [BIDX_W-1:0]   byte_index;
    logic [BYTE_W-1:0]   data_byte;
    modport source (output valid, req_type, rid_page, rid_slot, new_length,
                    byte_index, data_byte, input ready);
    modport sink (input valid, req_type, rid_page, rid_slot, new_length,
                  byte_index, data_byte, output ready);
endinterface

interface spr_rsp_if;
    import spr_pkg::*;
    logic                valid;
    logic                ready;
    logic [STS_W-1:0]    status;
    logic [PAGE_W-1:0]   out_page;
    logic [SLOT_W-1:0]   out_slot;
    logic [LEN_W-1:0]    out_length;
    logic [BYTE_W-1:0]   out_byte;
    logic [LEN_W-1:0]    free_bytes;
    logic                page_empty;
    modport source (output valid, status, out_page, out_slot, out_length,
                    out_byte, free_bytes, page_empty, input ready);
    modport sink (input valid, status, out_page, out_slot, out_length,
                  out_byte, free_bytes, page_empty, output ready);
endinterface

// ----- rtl/spr_ram.sv -----
// Generic simple dual port RAM with registered read.
module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/spr_ctrl.sv -----
// Sequencer of the page store: walks each request through its steps.
module spr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spr_pkg::t_cmd     o_cmd,
    input  spr_pkg::t_dp_stat i_stat
);
    import spr_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_FIN;
                case (i_stat.req)
                    REQ_INIT:      o_cmd.op = OP_INIT;
                    REQ_INS_BEGIN: begin
                        o_cmd.op = OP_INS_CLR;
                        n_state  = S_FINDE;
                    end
                    REQ_INS_BYTE:  o_cmd.op = OP_INS_BYTE;
                    REQ_DELETE: begin
                        if (i_stat.rid_ok) begin
                            o_cmd.op = OP_DEL_START;
                            n_state  = S_DEL_RD;
                        end else begin
                            o_cmd.op = OP_DEL_FAIL;
                        end
                    end
                    REQ_FIRST: begin
                        o_cmd.op = OP_SCAN_FROM0;
                        n_state  = S_FINDU;
                    end
                    REQ_NEXT: begin
                        if (i_stat.rid_ok) begin
                            o_cmd.op = OP_SCAN_NEXT;
                            n_state  = S_FINDU;
                        end else begin
                            o_cmd.op = OP_FAIL;
                        end
                    end
                    REQ_LENGTH, REQ_READ: begin
                        if (i_stat.rid_ok) begin
                            o_cmd.op = OP_SLOT_RD;
                            n_state  = S_SLOT_WAIT;
                        end else begin
                            o_cmd.op = OP_FAIL;
                        end
                    end
                    default: o_cmd.op = OP_NONE;
                endcase
            end
            // lowest empty slot, or append at the end
            S_FINDE: begin
                if (i_stat.idx_end || !i_stat.idx_used) begin
                    o_cmd.op = OP_INS_COMMIT;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_IDX_INC;
                end
            end
            // lowest used slot from the start index
            S_FINDU: begin
                if (i_stat.idx_end) begin
                    o_cmd.op = OP_SCAN_DONE;
                    n_state  = S_FIN;
                end else if (i_stat.idx_used) begin
                    o_cmd.op = OP_SCAN_HIT;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_IDX_INC;
                end
            end
            S_SLOT_WAIT: begin
                n_state = S_FIN;
                if (i_stat.req == REQ_LENGTH) begin
                    o_cmd.op = OP_LEN_OUT;
                end else if (i_stat.rd_ok) begin
                    o_cmd.op = OP_BYTE_RD;
                    n_state  = S_BYTE_WAIT;
                end else begin
                    o_cmd.op = OP_FAIL;
                end
            end
            S_BYTE_WAIT: begin
                o_cmd.op = OP_BYTE_OUT;
                n_state  = S_FIN;
            end
            S_DEL_RD: begin
                o_cmd.op = OP_DEL_LOAD;
                n_state  = S_MV_CHK;
            end
            // compaction: one byte read then written per pass
            S_MV_CHK: begin
                if (i_stat.mv_more) begin
                    o_cmd.op = OP_MV_RD;
                    n_state  = S_MV_WR;
                end else begin
                    o_cmd.op = OP_DEL_CLR;
                    n_state  = S_FIX_RD;
                end
            end
            S_MV_WR: begin
                o_cmd.op = OP_MV_WR;
                n_state  = S_MV_CHK;
            end
            // offset fix-up over the directory
            S_FIX_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.op = OP_DEL_SPACE;
                    n_state  = S_TRIM;
                end else if (i_stat.idx_used) begin
                    o_cmd.op = OP_FIX_RD;
                    n_state  = S_FIX_WR;
                end else begin
                    o_cmd.op = OP_IDX_INC;
                end
            end
            S_FIX_WR: begin
                o_cmd.op = OP_FIX_WR;
                n_state  = S_FIX_RD;
            end
            S_TRIM: begin
                if (i_stat.trim_more) begin
                    o_cmd.op = OP_TRIM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
endmodule

// ----- rtl/spr_dp.sv -----
// Datapath of the page store: page state, byte store and slot directory.
module spr_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [spr_pkg::PAGE_W-1:0]  i_cfg_data,
    input  logic [spr_pkg::REQ_W-1:0]   i_req_type,
    input  logic [spr_pkg::PAGE_W-1:0]  i_rid_page,
    input  logic [spr_pkg::SLOT_W-1:0]  i_rid_slot,
    input  logic [spr_pkg::LEN_W-1:0]   i_new_length,
    input  logic [spr_pkg::BIDX_W-1:0]  i_byte_index,
    input  logic [spr_pkg::BYTE_W-1:0]  i_data_byte,
    input  spr_pkg::t_cmd               i_cmd,
    output spr_pkg::t_dp_stat           o_stat,
    output logic [spr_pkg::STS_W-1:0]   o_status,
    output logic [spr_pkg::PAGE_W-1:0]  o_out_page,
    output logic [spr_pkg::SLOT_W-1:0]  o_out_slot,
    output logic [spr_pkg::LEN_W-1:0]   o_out_length,
    output logic [spr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic [spr_pkg::LEN_W-1:0]   o_free_bytes,
    output logic                        o_page_empty
);
    import spr_pkg::*;

    // page state
    logic [PAGE_W-1:0]    r_page_id;
    logic [MAX_SLOTS-1:0] r_used;
    logic [SCNT_W-1:0]    r_slot_count;
    logic [LEN_W-1:0]     r_low_mark;
    logic [LEN_W-1:0]     r_free;
    logic [LEN_W-1:0]     r_wptr;
    logic [LEN_W-1:0]     r_pend;
    logic [SCNT_W-1:0]    r_idx;

    // latched request
    logic [REQ_W-1:0]     r_req;
    logic [PAGE_W-1:0]    r_rpage;
    logic [SLOT_W-1:0]    r_rslot;
    logic [LEN_W-1:0]     r_nlen;
    logic [BIDX_W-1:0]    r_bidx;
    logic [BYTE_W-1:0]    r_dbyte;

    // delete working registers
    logic [LEN_W-1:0]     r_top;
    logic [LEN_W-1:0]     r_dlen;
    logic [LEN_W-1:0]     r_p;

    // result being built and the result register
    logic [STS_W-1:0]     r_status, r_o_status;
    logic [PAGE_W-1:0]    r_opage, r_o_page;
    logic [SLOT_W-1:0]    r_oslot, r_o_slot;
    logic [LEN_W-1:0]     r_olen, r_o_len;
    logic [BYTE_W-1:0]    r_obyte, r_o_byte;
    logic [LEN_W-1:0]     r_o_free;
    logic                 r_o_empty;

    // memory ports
    logic                 byte_we, byte_re;
    logic [ADDR_W-1:0]    byte_waddr, byte_raddr;
    logic [BYTE_W-1:0]    byte_wdata, byte_rdata;
    logic                 slot_we, slot_re;
    logic [SLOT_W-1:0]    slot_waddr, slot_raddr;
    logic [SRAM_W-1:0]    slot_wdata, slot_rdata;
    logic [LEN_W-1:0]     rd_off, rd_len;

    logic                 rid_ok, append, ins_fail, byte_fail, rd_ok;
    logic [LEN_W:0]       need;
    logic [LEN_W-1:0]     pos;
    logic [LEN_W-1:0]     free_bytes;
    logic [SCNT_W-1:0]    last_slot;

    assign rd_off = slot_rdata[SRAM_W-1:LEN_W];
    assign rd_len = slot_rdata[LEN_W-1:0];

    // request checks
    assign rid_ok = (r_rpage == r_page_id) && ({1'b0, r_rslot} < r_slot_count)
                    && r_used[r_rslot];
    assign append   = (r_idx == r_slot_count);
    assign need     = {1'b0, r_nlen} + (append ? (LEN_W+1)'(SLOT_BYTES) : '0);
    assign ins_fail = (append && (r_slot_count >= SCNT_W'(MAX_SLOTS)))
                      || ({1'b0, r_free} < need) || (r_low_mark < r_nlen);
    assign byte_fail = (r_pend == '0) || (r_wptr == '0)
                       || (r_wptr > LEN_W'(DATA_BYTES));
    assign rd_ok = ({1'b0, r_bidx} < rd_len) && ({1'b0, r_bidx} < rd_off);
    assign pos   = rd_off - LEN_W'(1) - {1'b0, r_bidx};
    assign free_bytes = (r_free > LEN_W'(SLOT_BYTES)) ? r_free - LEN_W'(SLOT_BYTES) : '0;
    assign last_slot  = r_slot_count - SCNT_W'(1);

    // status back to the sequencer
    always_comb begin
        o_stat.req       = r_req;
        o_stat.rid_ok    = rid_ok;
        o_stat.idx_end   = (r_idx >= r_slot_count);
        o_stat.idx_used  = r_used[r_idx[SLOT_W-1:0]];
        o_stat.rd_ok     = rd_ok;
        o_stat.mv_more   = (r_p > r_low_mark) && (r_dlen != '0);
        o_stat.trim_more = (r_slot_count != '0) && !r_used[last_slot[SLOT_W-1:0]];
    end

    // byte store port control
    always_comb begin
        byte_we    = 1'b0;
        byte_waddr = '0;
        byte_wdata = r_dbyte;
        byte_re    = 1'b0;
        byte_raddr = '0;
        case (i_cmd.op)
            OP_INS_BYTE: begin
                byte_we    = !byte_fail;
                byte_waddr = ADDR_W'(r_wptr - LEN_W'(1));
            end
            OP_MV_WR: begin
                byte_we    = 1'b1;
                byte_waddr = ADDR_W'(r_p + r_dlen);
                byte_wdata = byte_rdata;
            end
            OP_BYTE_RD: begin
                byte_re    = 1'b1;
                byte_raddr = pos[ADDR_W-1:0];
            end
            OP_MV_RD: begin
                byte_re    = 1'b1;
                byte_raddr = ADDR_W'(r_p - LEN_W'(1));
            end
            default: byte_we = 1'b0;
        endcase
    end

    // slot directory port control
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_idx[SLOT_W-1:0];
        slot_wdata = {r_low_mark, r_nlen};
        slot_re    = 1'b0;
        slot_raddr = r_rslot;
        case (i_cmd.op)
            OP_INS_COMMIT: slot_we = !ins_fail;
            OP_FIX_WR: begin
                slot_we    = (rd_off < r_top);
                slot_wdata = {rd_off + r_dlen, rd_len};
            end
            OP_DEL_START, OP_SLOT_RD: slot_re = 1'b1;
            OP_FIX_RD: begin
                slot_re    = 1'b1;
                slot_raddr = r_idx[SLOT_W-1:0];
            end
            default: slot_we = 1'b0;
        endcase
    end

    // page state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_id    <= '0;
            r_used       <= '0;
            r_slot_count <= '0;
            r_low_mark   <= LEN_W'(DATA_BYTES);
            r_free       <= LEN_W'(DATA_BYTES + SLOT_BYTES);
            r_wptr       <= '0;
            r_pend       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_page_id <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_INIT: begin
                    r_used       <= '0;
                    r_slot_count <= '0;
                    r_low_mark   <= LEN_W'(DATA_BYTES);
                    r_free       <= LEN_W'(DATA_BYTES + SLOT_BYTES);
                    r_wptr       <= '0;
                    r_pend       <= '0;
                end
                OP_INS_CLR, OP_DEL_START, OP_DEL_FAIL: r_pend <= '0;
                OP_INS_BYTE: begin
                    if (byte_fail) begin
                        r_pend <= '0;
                    end else begin
                        r_wptr <= r_wptr - LEN_W'(1);
                        r_pend <= r_pend - LEN_W'(1);
                    end
                end
                OP_INS_COMMIT: begin
                    if (!ins_fail) begin
                        if (append) begin
                            r_slot_count <= r_slot_count + SCNT_W'(1);
                        end
                        r_used[r_idx[SLOT_W-1:0]] <= 1'b1;
                        r_wptr     <= r_low_mark;
                        r_pend     <= r_nlen;
                        r_low_mark <= r_low_mark - r_nlen;
                        r_free     <= LEN_W'({1'b0, r_free} - need);
                    end
                end
                OP_DEL_CLR: r_used[r_rslot] <= 1'b0;
                OP_DEL_SPACE: begin
                    r_low_mark <= r_low_mark + r_dlen;
                    r_free     <= r_free + r_dlen;
                end
                OP_TRIM: begin
                    r_slot_count <= last_slot;
                    r_free       <= r_free + LEN_W'(SLOT_BYTES);
                end
                default: r_pend <= r_pend;
            endcase
        end
    end

    // request latch, scan index, delete registers and results
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_req    <= i_req_type;
                r_rpage  <= i_rid_page;
                r_rslot  <= i_rid_slot;
                r_nlen   <= i_new_length;
                r_bidx   <= i_byte_index;
                r_dbyte  <= i_data_byte;
                r_status <= ST_OK;
                r_opage  <= '0;
                r_oslot  <= '0;
                r_olen   <= '0;
                r_obyte  <= '0;
            end
            OP_INS_CLR, OP_SCAN_FROM0, OP_DEL_CLR: r_idx <= '0;
            OP_SCAN_NEXT: r_idx <= {1'b0, r_rslot} + SCNT_W'(1);
            OP_IDX_INC, OP_FIX_WR: r_idx <= r_idx + SCNT_W'(1);
            OP_INS_BYTE: begin
                if (byte_fail) begin
                    r_status <= ST_DONE;
                end
            end
            OP_INS_COMMIT: begin
                if (ins_fail) begin
                    r_status <= ST_DONE;
                end else begin
                    r_opage <= r_page_id;
                    r_oslot <= r_idx[SLOT_W-1:0];
                    r_olen  <= r_nlen;
                end
            end
            OP_DEL_FAIL, OP_FAIL: r_status <= ST_FAIL;
            OP_SCAN_DONE: r_status <= ST_DONE;
            OP_SCAN_HIT: begin
                r_opage <= r_page_id;
                r_oslot <= r_idx[SLOT_W-1:0];
            end
            OP_LEN_OUT, OP_BYTE_RD: r_olen <= rd_len;
            OP_BYTE_OUT: r_obyte <= byte_rdata;
            OP_DEL_LOAD: begin
                r_top  <= rd_off;
                r_dlen <= rd_len;
                r_p    <= rd_off - rd_len;
            end
            OP_MV_RD: r_p <= r_p - LEN_W'(1);
            OP_OUT_LOAD: begin
                r_o_status <= r_status;
                r_o_page   <= r_opage;
                r_o_slot   <= r_oslot;
                r_o_len    <= r_olen;
                r_o_byte   <= r_obyte;
                r_o_free   <= free_bytes;
                r_o_empty  <= (r_slot_count == '0);
            end
            default: r_idx <= r_idx;
        endcase
    end

    spr_ram #(.WIDTH(BYTE_W), .DEPTH(DATA_BYTES)) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_waddr (byte_waddr),
        .i_wdata (byte_wdata),
        .i_re    (byte_re),
        .i_raddr (byte_raddr),
        .o_rdata (byte_rdata)
    );

    spr_ram #(.WIDTH(SRAM_W), .DEPTH(MAX_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign o_status     = r_o_status;
    assign o_out_page   = r_o_page;
    assign o_out_slot   = r_o_slot;
    assign o_out_length = r_o_len;
    assign o_out_byte   = r_o_byte;
    assign o_free_bytes = r_o_free;
    assign o_page_empty = r_o_empty;
endmodule

// ----- rtl/slotted_page_record_store.sv -----
// Slotted page record store: one request in, one result out, one request
// at a time. Record length reads the slot directory, and read byte reads
// the directory and then the byte store. Insert begin, first and next scan
// the directory slot by slot. Delete moves the bytes below the record up
// one at a time during compaction, then fixes the offsets of the used
// directory slots, then trims the trailing empty slots. A result waits in
// its output register while the next request is worked on.
module slotted_page_record_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spr_pkg::PAGE_W-1:0] i_cfg_data,
    spr_req_if.sink                    i_req,
    spr_rsp_if.source                  o_rsp
);
    import spr_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    spr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    spr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req.req_type),
        .i_rid_page   (i_req.rid_page),
        .i_rid_slot   (i_req.rid_slot),
        .i_new_length (i_req.new_length),
        .i_byte_index (i_req.byte_index),
        .i_data_byte  (i_req.data_byte),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_status     (o_rsp.status),
        .o_out_page   (o_rsp.out_page),
        .o_out_slot   (o_rsp.out_slot),
        .o_out_length (o_rsp.out_length),
        .o_out_byte   (o_rsp.out_byte),
        .o_free_bytes (o_rsp.free_bytes),
        .o_page_empty (o_rsp.page_empty)
    );
endmodule

// ----- rtl/spr_checker.sv -----
// Port level checker of the page store and its bind.
`include "assert_macros.svh"
module spr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_req_valid,
    input logic                       i_req_ready,
    input logic                       i_rsp_valid,
    input logic                       i_rsp_ready,
    input logic [spr_pkg::STS_W-1:0]  i_status,
    input logic [spr_pkg::PAGE_W-1:0] i_out_page,
    input logic [spr_pkg::SLOT_W-1:0] i_out_slot,
    input logic [spr_pkg::LEN_W-1:0]  i_out_length,
    input logic [spr_pkg::BYTE_W-1:0] i_out_byte
);
    import spr_pkg::*;

    // a result beat stays offered until taken
    `SPR_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped while stalled")
    // status is one of the three codes
    `SPR_ASSERT(a_status_code, i_clk, i_rst_n, !i_rsp_valid || i_status == ST_OK || i_status == ST_DONE || i_status == ST_FAIL, "bad status code")
    // done and fail results carry no id, length or byte
    `SPR_ASSERT(a_zero_fields, i_clk, i_rst_n, !i_rsp_valid || i_status == ST_OK || (i_out_page == '0 && i_out_slot == '0 && i_out_length == '0 && i_out_byte == '0), "nonzero fields on done or fail")
    // one request at a time
    `SPR_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")
endmodule

bind slotted_page_record_store spr_checker u_spr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_out_page   (o_rsp.out_page),
    .i_out_slot   (o_rsp.out_slot),
    .i_out_length (o_rsp.out_length),
    .i_out_byte   (o_rsp.out_byte)
);

// ----- tb/slotted_page_record_store_tb.sv -----
// Self-checking testbench for the slotted page record store.
`timescale 1ns / 100ps

module slotted_page_record_store_tb;
    import spr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_QUERY   = 4'd8;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 4'd15;
    localparam int ITEMS_TARGET = 400;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [BIDX_W-1:0] idx;
        logic [BYTE_W-1:0] data;
    } page_req_t;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  free;
        logic              empty;
    } page_rsp_t;

    // directed row: request plus optional hand-written status/space/empty
    typedef struct packed {
        page_req_t         rq;
        logic              chk;
        logic [STS_W-1:0]  status;
        logic [LEN_W-1:0]  free;
        logic              empty;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [PAGE_W-1:0] i_cfg_data = '0;

    spr_req_if req_ch ();
    spr_rsp_if rsp_ch ();

    slotted_page_record_store u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow page state
    logic [7:0]        pg_bytes [DATA_BYTES];
    bit                pg_written [DATA_BYTES];
    int unsigned       pg_top [MAX_SLOTS];
    int unsigned       pg_len [MAX_SLOTS];
    bit                pg_used [MAX_SLOTS];
    int unsigned       pg_slots, pg_low, pg_free, pg_wptr, pg_pending;
    logic [PAGE_W-1:0] pg_id;

    page_rsp_t expected_rsps [$];
    int  n_items = 0;
    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    bit  hold_rsp = 1'b0;

    function automatic void page_clear();
        for (int i = 0; i < MAX_SLOTS; i++) pg_used[i] = 1'b0;
        pg_slots = 0;
        pg_low = DATA_BYTES;
        pg_free = DATA_BYTES + SLOT_BYTES;
        pg_wptr = 0;
        pg_pending = 0;
    endfunction

    function automatic bit rid_ok(logic [PAGE_W-1:0] page, int unsigned slot);
        return page == pg_id && slot < pg_slots && pg_used[slot];
    endfunction

    // advance the shadow page by one request and return its result
    function automatic page_rsp_t page_apply(page_req_t r);
        page_rsp_t o;
        int unsigned sel, need, top, ln, p, f, start;
        bit any;
        o = '0;
        o.status = ST_OK;
        case (r.req)
            REQ_INIT: page_clear();
            REQ_INS_BEGIN: begin
                sel = pg_slots;
                need = r.len;
                pg_pending = 0;
                for (int i = pg_slots - 1; i >= 0; i--)
                    if (!pg_used[i]) sel = i;
                if (sel == pg_slots) need += SLOT_BYTES;
                if ((sel == pg_slots && pg_slots >= MAX_SLOTS) || pg_free < need
                        || pg_low < r.len) begin
                    o.status = ST_DONE;
                end else begin
                    if (sel == pg_slots) begin
                        pg_slots++;
                        pg_free -= SLOT_BYTES;
                    end
                    pg_used[sel] = 1'b1;
                    pg_top[sel] = pg_low;
                    pg_len[sel] = r.len;
                    pg_wptr = pg_low;
                    pg_pending = r.len;
                    pg_low -= r.len;
                    pg_free -= r.len;
                    o.page = pg_id;
                    o.slot = SLOT_W'(sel);
                    o.len = r.len;
                end
            end
            REQ_INS_BYTE: begin
                if (pg_pending == 0 || pg_wptr == 0 || pg_wptr > DATA_BYTES) begin
                    pg_pending = 0;
                    o.status = ST_DONE;
                end else begin
                    pg_wptr--;
                    pg_bytes[pg_wptr] = r.data;
                    pg_written[pg_wptr] = 1'b1;
                    pg_pending--;
                end
            end
            REQ_DELETE: begin
                pg_pending = 0;
                if (!rid_ok(r.page, r.slot)) begin
                    o.status = ST_FAIL;
                end else begin
                    top = pg_top[r.slot];
                    ln = pg_len[r.slot];
                    p = top - ln;
                    // compaction: shift lower bytes up, top first
                    while (p > pg_low && ln > 0) begin
                        p--;
                        pg_bytes[p + ln] = pg_bytes[p];
                        pg_written[p + ln] = pg_written[p];
                    end
                    pg_used[r.slot] = 1'b0;
                    for (int i = 0; i < pg_slots; i++)
                        if (pg_used[i] && pg_top[i] < top) pg_top[i] += ln;
                    pg_low += ln;
                    pg_free += ln;
                    while (pg_slots > 0 && !pg_used[pg_slots - 1]) begin
                        pg_slots--;
                        pg_free += SLOT_BYTES;
                    end
                end
            end
            REQ_FIRST, REQ_NEXT: begin
                start = 0;
                if (r.req == REQ_NEXT && !rid_ok(r.page, r.slot)) begin
                    o.status = ST_FAIL;
                end else begin
                    if (r.req == REQ_NEXT) start = r.slot + 1;
                    f = pg_slots;
                    for (int i = pg_slots - 1; i >= int'(start); i--)
                        if (pg_used[i]) f = i;
                    if (f >= pg_slots) begin
                        o.status = ST_DONE;
                    end else begin
                        o.page = pg_id;
                        o.slot = SLOT_W'(f);
                    end
                end
            end
            REQ_LENGTH, REQ_READ: begin
                if (!rid_ok(r.page, r.slot)) begin
                    o.status = ST_FAIL;
                end else if (r.req == REQ_LENGTH) begin
                    o.len = LEN_W'(pg_len[r.slot]);
                end else if (r.idx >= pg_len[r.slot] || r.idx >= pg_top[r.slot]) begin
                    o.status = ST_FAIL;
                end else begin
                    o.len = LEN_W'(pg_len[r.slot]);
                    o.data = pg_bytes[pg_top[r.slot] - 1 - r.idx];
                end
            end
            default: ;
        endcase
        o.free = LEN_W'((pg_free > SLOT_BYTES) ? pg_free - SLOT_BYTES : 0);
        any = 1'b0;
        for (int i = 0; i < pg_slots; i++) any |= pg_used[i];
        o.empty = !any;
        return o;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offer one request beat and record what it must produce
    task automatic send(input page_req_t r, output page_rsp_t exp_rsp);
        @(negedge i_clk);
        req_ch.valid      = 1'b1;
        req_ch.req_type   = r.req;
        req_ch.rid_page   = r.page;
        req_ch.rid_slot   = r.slot;
        req_ch.new_length = r.len;
        req_ch.byte_index = r.idx;
        req_ch.data_byte  = r.data;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        exp_rsp = page_apply(r);
        expected_rsps.push_back(exp_rsp);
        n_items++;
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        repeat (gap_len()) @(negedge i_clk);
    endtask

    function automatic page_req_t mk(logic [REQ_W-1:0] q, int unsigned pg,
                                     int sl, int ln, int ix, int d);
        page_req_t r;
        r.req = q;
        r.page = PAGE_W'(pg);
        r.slot = SLOT_W'(sl);
        r.len = LEN_W'(ln);
        r.idx = BIDX_W'(ix);
        r.data = BYTE_W'(d);
        return r;
    endfunction

    function automatic page_req_t noise_req();
        page_req_t r;
        r = $bits(page_req_t)'({$urandom, $urandom, $urandom});
        r.page = ($urandom_range(0, 1)) ? pg_id : r.page;
        return r;
    endfunction

    task automatic drain();
        while (expected_rsps.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_page_id(input logic [PAGE_W-1:0] v);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pg_id = v;
    endtask

    function automatic int used_slot();
        int c, k;
        c = 0;
        for (int i = 0; i < pg_slots; i++) c += pg_used[i];
        if (c == 0) return -1;
        k = $urandom_range(0, c - 1);
        for (int i = 0; i < pg_slots; i++)
            if (pg_used[i]) begin
                if (k == 0) return i;
                k--;
            end
        return -1;
    endfunction

    // insert a record and write its bytes, sometimes breaking off early
    task automatic insert_record(input int ln, input bit may_cut);
        page_rsp_t e;
        int n;
        send(mk(REQ_INS_BEGIN, 0, 0, ln, 0, 0), e);
        if (e.status != ST_OK) return;
        n = (may_cut && $urandom_range(0, 9) == 0) ? $urandom_range(0, ln) : ln;
        for (int i = 0; i < n; i++)
            send(mk(REQ_INS_BYTE, $urandom, $urandom, $urandom, $urandom, $urandom), e);
    endtask

    task automatic random_items(input int count);
        page_rsp_t e;
        page_req_t r;
        int stop, k, s, ix;
        stop = n_items + count;
        while (n_items < stop) begin
            k = $urandom_range(0, 99);
            s = used_slot();
            if (k < 30) begin
                k = $urandom_range(0, 29);
                insert_record(k == 0 ? $urandom_range(0, 2047) :
                              k < 4 ? $urandom_range(17, 120) : $urandom_range(0, 16), 1);
            end else if (k < 45) begin
                if (s < 0 || $urandom_range(0, 9) == 0) begin
                    r = noise_req();
                    r.req = REQ_DELETE;
                    send(r, e);
                end else begin
                    send(mk(REQ_DELETE, pg_id, s, 0, 0, 0), e);
                end
            end else if (k < 55) begin
                send(mk(REQ_FIRST, $urandom, $urandom, $urandom, $urandom, $urandom), e);
                while (e.status == ST_OK && $urandom_range(0, 3) != 0)
                    send(mk(REQ_NEXT, e.page, e.slot, 0, 0, 0), e);
            end else if (k < 68) begin
                send(mk(REQ_LENGTH, pg_id, s < 0 ? $urandom : s, 0, 0, 0), e);
            end else if (k < 88) begin
                r = mk(REQ_READ, pg_id, s < 0 ? $urandom : s, 0, $urandom, $urandom);
                if (s >= 0 && pg_len[s] > 0 && $urandom_range(0, 5) != 0)
                    r.idx = $urandom_range(0, pg_len[s] - 1);
                // never touch a byte that was not written
                if (rid_ok(r.page, r.slot) && r.idx < pg_len[s] && r.idx < pg_top[s]) begin
                    ix = pg_top[s] - 1 - r.idx;
                    if (!pg_written[ix]) r.req = REQ_LENGTH;
                end
                send(r, e);
            end else if (k < 95) begin
                r = noise_req();
                k = $urandom_range(0, 3);
                r.req = k == 0 ? REQ_INS_BYTE : k == 1 ? REQ_NEXT :
                        k == 2 ? REQ_LENGTH : 4'($urandom_range(9, 15));
                send(r, e);
            end else if (k < 97) begin
                send(mk(REQ_INIT, $urandom, $urandom, $urandom, $urandom, $urandom), e);
            end else begin
                send(mk(REQ_QUERY, 0, 0, 0, 0, 0), e);
            end
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        page_rsp_t a, x;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            a = {rsp_ch.status, rsp_ch.out_page, rsp_ch.out_slot, rsp_ch.out_length,
                 rsp_ch.out_byte, rsp_ch.free_bytes, rsp_ch.page_empty};
            if (expected_rsps.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat %h", a);
            end else begin
                x = expected_rsps.pop_front();
                if (a !== x) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp st=%0d pg=%h sl=%0d len=%0d b=%h fr=%0d e=%0b",
                                 x.status, x.page, x.slot, x.len, x.data, x.free, x.empty,
                                 " / got st=%0d pg=%h sl=%0d len=%0d b=%h fr=%0d e=%0b",
                                 a.status, a.page, a.slot, a.len, a.data, a.free, a.empty);
                end
            end
        end
    end

    // result-side stalls, with one long hold-off on request
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rsp = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("** slotted_page_record_store: FAILED **");
            $finish;
        end
    end

    initial begin
        dir_row_t rows [$];
        page_rsp_t e;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.rid_page = '0;
        req_ch.rid_slot = '0;
        req_ch.new_length = '0;
        req_ch.byte_index = '0;
        req_ch.data_byte = '0;
        pg_id = '0;
        page_clear();
        for (int i = 0; i < DATA_BYTES; i++) begin
            pg_bytes[i] = '0;
            pg_written[i] = 1'b0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows on page 0
        write_page_id('0);
        rows.push_back({mk(REQ_QUERY, 0, 0, 0, 0, 0), 1'b1, ST_OK, 11'd1024, 1'b1});
        rows.push_back({mk(REQ_FIRST, 0, 0, 0, 0, 0), 1'b1, ST_DONE, 11'd1024, 1'b1});
        rows.push_back({mk(REQ_LENGTH, 0, 0, 0, 0, 0), 1'b1, ST_FAIL, 11'd1024, 1'b1});
        rows.push_back({mk(REQ_INS_BEGIN, 0, 0, 1025, 0, 0), 1'b1, ST_DONE, 11'd1024, 1'b1});
        rows.push_back({mk(REQ_INS_BEGIN, 0, 0, 0, 0, 0), 1'b1, ST_OK, 11'd1020, 1'b0});
        rows.push_back({mk(REQ_INS_BEGIN, 0, 0, 3, 0, 0), 1'b1, ST_OK, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'h00), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'hFF), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'hA5), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'h3C), 1'b1, ST_DONE, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_READ, 0, 1, 0, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_READ, 0, 1, 0, 2, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_READ, 0, 1, 0, 3, 0), 1'b1, ST_FAIL, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_READ, 0, 1, 0, 1023, 0), 1'b1, ST_FAIL, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_LENGTH, 0, 1, 0, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_FIRST, 0, 0, 0, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_NEXT, 0, 0, 0, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_NEXT, 0, 1, 0, 0, 0), 1'b1, ST_DONE, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_NEXT, '1, 63, 0, 0, 0), 1'b1, ST_FAIL, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_UNKNOWN, '1, 63, 2047, 1023, 255), 1'b1, ST_OK, 11'd1013, 1'b0});
        rows.push_back({mk(REQ_INS_BEGIN, 0, 0, 2, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'h11), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_DELETE, 0, 1, 0, 0, 0), 1'b0, ST_OK, 11'd0, 1'b0});
        rows.push_back({mk(REQ_DELETE, 0, 1, 0, 0, 0), 1'b1, ST_FAIL, 11'd1010, 1'b0});
        rows.push_back({mk(REQ_INIT, 0, 0, 0, 0, 0), 1'b1, ST_OK, 11'd1024, 1'b1});
        foreach (rows[i]) begin
            send(rows[i].rq, e);
            if (rows[i].chk && {e.status, e.free, e.empty} !==
                    {rows[i].status, rows[i].free, rows[i].empty}) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("directed row %0d: table st=%0d fr=%0d e=%0b, model st=%0d fr=%0d",
                             i, rows[i].status, rows[i].free, rows[i].empty, e.status, e.free);
            end
        end

        // top page id, no idling for a stretch
        write_page_id({PAGE_W{1'b1}});
        quiet = 1'b1;
        random_items(60);
        quiet = 1'b0;
        random_items(90);

        // long result hold-off while requests keep coming
        hold_rsp = 1'b1;
        random_items(40);
        drain();

        // directory full, then tear down
        write_page_id(PAGE_W'($urandom));
        send(mk(REQ_INIT, 0, 0, 0, 0, 0), e);
        for (int i = 0; i <= MAX_SLOTS; i++) insert_record(0, 0);
        random_items(40);

        // one record that takes the whole page, only its first bytes written
        send(mk(REQ_INIT, 0, 0, 0, 0, 0), e);
        send(mk(REQ_INS_BEGIN, 0, 0, DATA_BYTES, 0, 0), e);
        send(mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'h5A), e);
        send(mk(REQ_INS_BYTE, 0, 0, 0, 0, 8'hC3), e);
        send(mk(REQ_READ, pg_id, 0, 0, 0, 0), e);
        send(mk(REQ_READ, pg_id, 0, 0, 1, 0), e);
        send(mk(REQ_LENGTH, pg_id, 0, 0, 0, 0), e);
        send(mk(REQ_INS_BEGIN, 0, 0, 0, 0, 0), e);
        send(mk(REQ_DELETE, pg_id, 0, 0, 0, 0), e);

        write_page_id(PAGE_W'($urandom));
        random_items(ITEMS_TARGET / 4);

        drain();
        repeat (50) @(negedge i_clk);
        if (n_errors == 0 && expected_rsps.size() == 0)
            $display("** slotted_page_record_store: PASSED **");
        else
            $display("** slotted_page_record_store: FAILED **");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_intf.sv
rtl/spr_ram.sv
rtl/spr_ctrl.sv
rtl/spr_dp.sv
rtl/slotted_page_record_store.sv
rtl/spr_checker.sv
tb/slotted_page_record_store_tb.sv
